/* hdl/swdm_pkg.sv */
// Shared constants, types and state codes for the sliding window distinct-count block.
package swdm_pkg;

    // Parameter defaults
    localparam int VALUE_COUNT_DEF = 1024;
    localparam int WINDOW_MAX_DEF  = 256;

    // Fixed field widths
    localparam int VALUE_W   = 10;
    localparam int SIZE_W    = 9;
    localparam int OUT_CNT_W = 9;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = '0;
    localparam logic [SIZE_W-1:0]    SIZE_RESET      = SIZE_W'(1);

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_C0,
        ST_C1,
        ST_C2,
        ST_EMIT,
        ST_DR0,
        ST_DR1,
        ST_DR2
    } ctrl_state_t;

    // One result beat
    typedef struct packed {
        logic [OUT_CNT_W-1:0] distinct_now;
        logic                 window_full;
        logic [OUT_CNT_W-1:0] min_distinct;
        logic                 min_valid;
        logic                 sequence_done;
    } result_t;

endpackage

/* hdl/swdm_if.sv */
// Valid/ready channel interfaces for input items and results.
interface swdm_item_if;
    import swdm_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               end_of_sequence;

    modport source (output valid, output value, output end_of_sequence, input ready);
    modport sink   (input valid, input value, input end_of_sequence, output ready);
endinterface

interface swdm_result_if;
    import swdm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_CNT_W-1:0] distinct_now;
    logic                 window_full;
    logic [OUT_CNT_W-1:0] min_distinct;
    logic                 min_valid;
    logic                 sequence_done;

    modport source (output valid, output distinct_now, output window_full,
                    output min_distinct, output min_valid, output sequence_done,
                    input ready);
    modport sink   (input valid, input distinct_now, input window_full,
                    input min_distinct, input min_valid, input sequence_done,
                    output ready);
endinterface

/* hdl/swdm_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module swdm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/swdm_apb_regs.sv */
// APB-style configuration register holding the window size.
module swdm_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swdm_pkg::PADDR_W-1:0]    paddr,
    input  logic [swdm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swdm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [swdm_pkg::SIZE_W-1:0]     window_size
);
    import swdm_pkg::*;

    logic [SIZE_W-1:0]    window_size_reg;
    logic [SIZE_W-1:0]    window_size_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // write decode
    always_comb
    begin
        window_size_next = window_size_reg;
        if (wr_en && (reg_idx == REG_WINDOW_SIZE))
        begin
            window_size_next = pwdata[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= SIZE_RESET;
        end
        else
        begin
            window_size_reg <= window_size_next;
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_WINDOW_SIZE)
        begin
            prdata = APB_DATA_W'(window_size_reg);
        end
    end

    assign window_size = window_size_reg;

endmodule

/* hdl/swdm_ctrl.sv */
// Sequencer and datapath: read-modify-write of the count table and window store.
module swdm_ctrl #(
    parameter int VALUE_COUNT = swdm_pkg::VALUE_COUNT_DEF,
    parameter int WINDOW_MAX  = swdm_pkg::WINDOW_MAX_DEF,
    parameter int VAL_AW      = $clog2(VALUE_COUNT),
    parameter int CNT_W       = $clog2(WINDOW_MAX + 1),
    parameter int PTR_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    swdm_item_if.sink                   item,
    swdm_result_if.source               result,
    input  logic [swdm_pkg::SIZE_W-1:0] window_size,
    // count table port
    output logic                        cnt_we,
    output logic [VAL_AW-1:0]           cnt_waddr,
    output logic [CNT_W-1:0]            cnt_wdata,
    output logic [VAL_AW-1:0]           cnt_raddr,
    input  logic [CNT_W-1:0]            cnt_rdata,
    // window store port
    output logic                        st_we,
    output logic [PTR_W-1:0]            st_waddr,
    output logic [VAL_AW-1:0]           st_wdata,
    output logic [PTR_W-1:0]            st_raddr,
    input  logic [VAL_AW-1:0]           st_rdata
);
    import swdm_pkg::*;

    // reduce an input value into the table range, one conditional subtract per bit
    function automatic logic [VAL_AW-1:0] reduce_value(input logic [VALUE_W-1:0] x);
        logic [VALUE_W-1:0]        r;
        logic [VAL_AW+VALUE_W-1:0] w;
        r = x;
        for (int k = VALUE_W - 1; k >= 0; k--)
        begin
            if ((32'(r) >> k) >= 32'(VALUE_COUNT))
            begin
                r = r - VALUE_W'(32'(VALUE_COUNT) << k);
            end
        end
        w = (VAL_AW + VALUE_W)'(r);
        return w[VAL_AW-1:0];
    endfunction

    ctrl_state_t state_reg, state_next;

    logic [VAL_AW-1:0] v_reg, v_next;
    logic [VAL_AW-1:0] v_old_reg, v_old_next;
    logic              last_reg, last_next;
    logic              drop_reg, drop_next;
    logic              same_reg, same_next;
    logic              inc_reg, inc_next;
    logic              drain_reg, drain_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  dist_reg, dist_next;
    logic [CNT_W-1:0]  best_reg, best_next;
    logic              best_valid_reg, best_valid_next;
    logic [VAL_AW-1:0] clr_reg, clr_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [CNT_W-1:0]  fwd_data_reg, fwd_data_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    result_t           res_reg, res_next;

    logic [CNT_W-1:0]  size_eff;
    logic [CNT_W:0]    h_ext;
    logic [CNT_W:0]    f_ext;
    logic [CNT_W:0]    pos_ext;
    logic [PTR_W-1:0]  oldest;
    logic [PTR_W-1:0]  head_inc;
    logic [CNT_W-1:0]  cnt_eff;
    logic [VAL_AW-1:0] v_in;
    logic              item_ready;
    logic              accept;
    logic              out_free;

    logic              same_c;
    logic              dec_c;
    logic [CNT_W-1:0]  dist_mid;
    logic [CNT_W-1:0]  dist_new;
    logic [CNT_W-1:0]  best_upd;
    logic              best_valid_upd;
    logic              full_c;
    result_t           res_c;

    // effective window size: zero acts as one, clamp to the store depth
    always_comb
    begin
        if (window_size == '0)
        begin
            size_eff = CNT_W'(1);
        end
        else if (32'(window_size) > 32'(WINDOW_MAX))
        begin
            size_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            size_eff = CNT_W'(window_size);
        end
    end

    // oldest entry position and head increment
    assign h_ext    = (CNT_W + 1)'(head_reg);
    assign f_ext    = (CNT_W + 1)'(fill_reg);
    assign pos_ext  = (h_ext >= f_ext) ? (h_ext - f_ext)
                                       : (h_ext + (CNT_W + 1)'(WINDOW_MAX) - f_ext);
    assign oldest   = pos_ext[PTR_W-1:0];
    assign head_inc = (head_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : head_reg + PTR_W'(1);

    // count read data with bypass of a write that hit the same entry
    assign cnt_eff = fwd_hit_reg ? fwd_data_reg : cnt_rdata;

    assign v_in       = reduce_value(item.value);
    assign out_free   = !out_valid_reg || result.ready;
    assign item_ready = (state_reg == ST_IDLE) ||
                        ((state_reg == ST_C2) && out_free && !last_reg);
    assign accept     = item.valid && item_ready;
    assign item.ready = item_ready;

    // update arithmetic of the finishing step
    always_comb
    begin
        same_c   = drop_reg && (st_rdata == v_reg);
        dec_c    = drop_reg && !same_reg && (cnt_eff != '0);
        dist_mid = (dec_c && (cnt_eff == CNT_W'(1)) && (dist_reg != '0))
                   ? dist_reg - CNT_W'(1) : dist_reg;
        dist_new = dist_mid + CNT_W'(inc_reg);
        full_c   = (fill_reg == size_eff);
        best_upd       = best_reg;
        best_valid_upd = best_valid_reg;
        if (full_c && (!best_valid_reg || (dist_new < best_reg)))
        begin
            best_upd       = dist_new;
            best_valid_upd = 1'b1;
        end
        res_c.distinct_now  = OUT_CNT_W'(dist_new);
        res_c.window_full   = full_c;
        res_c.min_distinct  = best_valid_upd ? OUT_CNT_W'(best_upd) : '0;
        res_c.min_valid     = best_valid_upd;
        res_c.sequence_done = last_reg;
    end

    // next state and memory control
    always_comb
    begin
        state_next      = state_reg;
        v_next          = v_reg;
        v_old_next      = v_old_reg;
        last_next       = last_reg;
        drop_next       = drop_reg;
        same_next       = same_reg;
        inc_next        = inc_reg;
        drain_next      = drain_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        dist_next       = dist_reg;
        best_next       = best_reg;
        best_valid_next = best_valid_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_next        = out_reg;
        res_next        = res_reg;

        cnt_we    = 1'b0;
        cnt_waddr = v_reg;
        cnt_wdata = '0;
        cnt_raddr = v_reg;
        st_we     = 1'b0;
        st_waddr  = head_reg;
        st_wdata  = v_reg;
        st_raddr  = oldest;

        case (state_reg)
            ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                if (clr_reg == VAL_AW'(VALUE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + VAL_AW'(1);
                end
            end

            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end

            // item start after extra drops
            ST_C0:
            begin
                cnt_raddr  = v_reg;
                st_raddr   = oldest;
                drop_next  = (fill_reg >= size_eff);
                state_next = ST_C1;
            end

            // oldest value known: bump the entering count, fetch the leaving one
            ST_C1:
            begin
                same_next  = same_c;
                inc_next   = !same_c && (cnt_eff == '0);
                v_old_next = st_rdata;
                if (!same_c)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = v_reg;
                    cnt_wdata = cnt_eff + CNT_W'(1);
                end
                cnt_raddr = st_rdata;
                st_we     = 1'b1;
                st_waddr  = head_reg;
                st_wdata  = v_reg;
                head_next = head_inc;
                fill_next = drop_reg ? fill_reg : fill_reg + CNT_W'(1);
                state_next = ST_C2;
            end

            // write back the leaving count and form the result
            ST_C2:
            begin
                if (dec_c)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = v_old_reg;
                    cnt_wdata = cnt_eff - CNT_W'(1);
                end
                dist_next = dist_new;
                res_next  = res_c;
                if (last_reg)
                begin
                    best_next       = '0;
                    best_valid_next = 1'b0;
                end
                else
                begin
                    best_next       = best_upd;
                    best_valid_next = best_valid_upd;
                end
                if (out_free)
                begin
                    out_next       = res_c;
                    out_valid_next = 1'b1;
                    drain_next     = 1'b1;
                    state_next     = last_reg ? ST_DR0 : ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    drain_next     = 1'b1;
                    state_next     = last_reg ? ST_DR0 : ST_IDLE;
                end
            end

            // single drop: read store, read count, write back
            ST_DR0:
            begin
                st_raddr   = oldest;
                state_next = ST_DR1;
            end

            ST_DR1:
            begin
                cnt_raddr  = st_rdata;
                v_old_next = st_rdata;
                state_next = ST_DR2;
            end

            ST_DR2:
            begin
                if (cnt_eff != '0)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = v_old_reg;
                    cnt_wdata = cnt_eff - CNT_W'(1);
                    if ((cnt_eff == CNT_W'(1)) && (dist_reg != '0))
                    begin
                        dist_next = dist_reg - CNT_W'(1);
                    end
                end
                fill_next = fill_reg - CNT_W'(1);
                if (drain_reg)
                begin
                    if (fill_reg == CNT_W'(1))
                    begin
                        head_next  = '0;
                        dist_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DR0;
                    end
                end
                else if ((fill_reg - CNT_W'(1)) > size_eff)
                begin
                    state_next = ST_DR0;
                end
                else
                begin
                    state_next = ST_C0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // new item beat: start reads now, or run extra drops first
        if (accept)
        begin
            v_next    = v_in;
            last_next = item.end_of_sequence;
            if (fill_reg > size_eff)
            begin
                drain_next = 1'b0;
                state_next = ST_DR0;
            end
            else
            begin
                cnt_raddr  = v_in;
                st_raddr   = oldest;
                drop_next  = (fill_reg >= size_eff);
                state_next = ST_C1;
            end
        end
    end

    // bypass capture for a read that meets a write
    assign fwd_hit_next  = cnt_we && (cnt_waddr == cnt_raddr);
    assign fwd_data_next = cnt_wdata;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            drain_reg      <= 1'b0;
            head_reg       <= '0;
            fill_reg       <= '0;
            dist_reg       <= '0;
            best_reg       <= '0;
            best_valid_reg <= 1'b0;
            clr_reg        <= '0;
            fwd_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
            drop_reg       <= 1'b0;
            same_reg       <= 1'b0;
            inc_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            drain_reg      <= drain_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            dist_reg       <= dist_next;
            best_reg       <= best_next;
            best_valid_reg <= best_valid_next;
            clr_reg        <= clr_next;
            fwd_hit_reg    <= fwd_hit_next;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
            drop_reg       <= drop_next;
            same_reg       <= same_next;
            inc_reg        <= inc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        v_old_reg    <= v_old_next;
        fwd_data_reg <= fwd_data_next;
        out_reg      <= out_next;
        res_reg      <= res_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.distinct_now  = out_reg.distinct_now;
    assign result.window_full   = out_reg.window_full;
    assign result.min_distinct  = out_reg.min_distinct;
    assign result.min_valid     = out_reg.min_valid;
    assign result.sequence_done = out_reg.sequence_done;

endmodule

/* hdl/sliding_window_distinct_min_unit.sv */
// Top level of the sliding window distinct-count unit with running minimum.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  item     | in  | valid/ready            | value, end_of_sequence
//  result   | out | valid/ready            | distinct_now, window_full, min_distinct,
//           |     |                        | min_valid, sequence_done
//  apb      | in  | psel/penable/pwrite    | paddr, pwdata, prdata (window_size @ 0x0)
//
// An item's result is registered via states C1 and C2; a new beat can be taken in C2
// when the output is free and no sequence ends, paced by the two count table read-modify-writes.
// A lowered window size runs DR0, DR1, DR2 per extra leaving value, then restarts the item in C0.
// After an end_of_sequence beat the window is drained through DR0, DR1, DR2 per stored value.
// After reset every entry of the count table is swept clear before any item is taken.
// A stalled result is held in the output register; one more item may be taken meanwhile.
module sliding_window_distinct_min_unit #(
    parameter int VALUE_COUNT = swdm_pkg::VALUE_COUNT_DEF,
    parameter int WINDOW_MAX  = swdm_pkg::WINDOW_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    swdm_item_if.sink                       item,
    swdm_result_if.source                   result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swdm_pkg::PADDR_W-1:0]    paddr,
    input  logic [swdm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swdm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import swdm_pkg::*;

    localparam int VAL_AW = $clog2(VALUE_COUNT);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [SIZE_W-1:0] window_size;

    logic              cnt_we;
    logic [VAL_AW-1:0] cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [VAL_AW-1:0] cnt_raddr;
    logic [CNT_W-1:0]  cnt_rdata;

    logic              st_we;
    logic [PTR_W-1:0]  st_waddr;
    logic [VAL_AW-1:0] st_wdata;
    logic [PTR_W-1:0]  st_raddr;
    logic [VAL_AW-1:0] st_rdata;

    // configuration register
    swdm_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .window_size (window_size)
    );

    // per-value count table
    swdm_ram #(
        .DEPTH (VALUE_COUNT),
        .WIDTH (CNT_W),
        .AW    (VAL_AW)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // circular window store
    swdm_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (VAL_AW),
        .AW    (PTR_W)
    ) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // sequencer
    swdm_ctrl #(
        .VALUE_COUNT (VALUE_COUNT),
        .WINDOW_MAX  (WINDOW_MAX),
        .VAL_AW      (VAL_AW),
        .CNT_W       (CNT_W),
        .PTR_W       (PTR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .window_size (window_size),
        .cnt_we      (cnt_we),
        .cnt_waddr   (cnt_waddr),
        .cnt_wdata   (cnt_wdata),
        .cnt_raddr   (cnt_raddr),
        .cnt_rdata   (cnt_rdata),
        .st_we       (st_we),
        .st_waddr    (st_waddr),
        .st_wdata    (st_wdata),
        .st_raddr    (st_raddr),
        .st_rdata    (st_rdata)
    );

endmodule
